[src/frp_pkg.sv]
package frp_pkg;

    // Frame delimiters.
    localparam logic [7:0] START_MARK = 8'h02;
    localparam logic [7:0] END_MARK   = 8'h03;

    // Reset value of the command payload limit register.
    localparam logic [15:0] CMD_LIMIT_RESET = 16'd2048;

    // Number of check bytes that follow the payload.
    localparam logic [2:0] CHECK_BYTES = 3'd4;

    // Input kinds.
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Result event codes.
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_PRINT     = 3'd1;
    localparam logic [2:0] EV_CMD       = 3'd2;
    localparam logic [2:0] EV_DONE      = 3'd3;
    localparam logic [2:0] EV_TOO_LARGE = 3'd4;
    localparam logic [2:0] EV_FULL      = 3'd5;
    localparam logic [2:0] EV_NO_END    = 3'd6;

    // One input item.
    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } frp_in_t;

    // One result item.
    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic [7:0]  frame_type;
        logic [7:0]  frame_index;
        logic [15:0] frame_len;
        logic [16:0] print_count;
        logic        resynced;
    } frp_out_t;

    // Control handed from the pipeline to the parser.
    typedef struct packed {
        logic       step;
        logic [15:0] cmd_limit;
    } frp_ctrl_t;

endpackage

[src/framed_packet_receiver.sv]
// Framed packet receiver: parses a byte stream of frames (start byte 0x02,
// type, index, 16-bit little-endian length, payload, four unchecked check
// bytes, end byte 0x03) and returns one result item for every input item.
// Payload bytes of print frames (type 0) come out as writes at the running
// print count, those of other frames as writes at their payload offset.
// The block takes one item per clock cycle while its results are taken;
// each item passes an input register and then a result register before
// its result is offered. The frame state is updated once per item, which
// is what sets that rate. A waiting result lets at most one more
// item into the input register; after that the input is held off until the
// result is taken. The command payload limit is written through the
// configuration channel, which is always ready; it resets to 2048.
module framed_packet_receiver #(
    parameter int PRINT_BUFFER_BYTES = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  frp_pkg::frp_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output frp_pkg::frp_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);

    logic               in_valid_reg;
    frp_pkg::frp_in_t   in_item_reg;
    logic               out_valid_reg;
    frp_pkg::frp_out_t  out_item_reg;
    logic [15:0]        cmd_limit_reg;
    logic               advance;
    frp_pkg::frp_ctrl_t ctrl;
    frp_pkg::frp_out_t  result;

    // The result register can take a new item when empty or being drained.
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign ctrl.step      = in_valid_reg && advance;
    assign ctrl.cmd_limit = cmd_limit_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_limit_reg <= frp_pkg::CMD_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cmd_limit_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (ctrl.step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    frp_parser #(
        .PRINT_BUFFER_BYTES(PRINT_BUFFER_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (in_item_reg),
        .result (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            out_item_reg <= result;
        end
    end

endmodule

[src/frp_parser.sv]
module frp_parser #(
    parameter int PRINT_BUFFER_BYTES = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  frp_pkg::frp_ctrl_t ctrl,
    input  frp_pkg::frp_in_t  item,
    output frp_pkg::frp_out_t result
);

    localparam int FILL_W = $clog2(PRINT_BUFFER_BYTES + 1);
    localparam int SUM_W  = ((FILL_W > 16) ? FILL_W : 16) + 1;

    typedef enum logic [7:0] {
        PH_WAIT    = 8'b0000_0001,
        PH_TYPE    = 8'b0000_0010,
        PH_INDEX   = 8'b0000_0100,
        PH_LEN_LO  = 8'b0000_1000,
        PH_LEN_HI  = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_CHECK   = 8'b0100_0000,
        PH_END     = 8'b1000_0000
    } frp_phase_t;

    frp_phase_t        phase_reg, phase_next;
    logic [7:0]        type_reg, type_next;
    logic [7:0]        index_reg, index_next;
    logic [15:0]       len_reg, len_next;
    logic [15:0]       pos_reg, pos_next;
    logic [2:0]        check_reg, check_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] start_fill_reg, start_fill_next;

    logic [7:0]        b;
    logic [15:0]       len_full;
    logic [SUM_W-1:0]  fill_sum;
    logic [15:0]       pos_inc;
    logic [2:0]        check_inc;
    logic [FILL_W-1:0] rollback_fill;
    logic              abort;
    logic              keep_hdr;
    logic [15:0]       kept_len;
    logic [2:0]        ev;
    logic [15:0]       addr;
    logic [7:0]        data;
    logic              resync;

    assign b         = item.rx_byte;
    assign len_full  = {b, len_reg[7:0]};
    assign fill_sum  = SUM_W'(fill_reg) + SUM_W'(len_full);
    assign pos_inc   = pos_reg + 16'd1;
    assign check_inc = check_reg + 3'd1;

    // An aborted print frame gives back the bytes it had already written.
    assign rollback_fill = (type_reg == 8'd0 && fill_reg > start_fill_reg) ?
                           start_fill_reg : fill_reg;

    // Parse one item against the current frame state.
    always_comb
    begin
        phase_next      = phase_reg;
        type_next       = type_reg;
        index_next      = index_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        check_next      = check_reg;
        fill_next       = fill_reg;
        start_fill_next = start_fill_reg;
        ev              = frp_pkg::EV_NONE;
        addr            = 16'd0;
        data            = 8'd0;
        resync          = 1'b0;
        abort           = 1'b0;
        keep_hdr        = 1'b0;
        kept_len        = len_reg;

        if (item.kind == frp_pkg::KIND_CLEAR)
        begin
            fill_next = '0;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (b == frp_pkg::START_MARK)
                    begin
                        start_fill_next = fill_reg;
                        phase_next      = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = b;
                    phase_next = PH_INDEX;
                end
                PH_INDEX:
                begin
                    index_next = b;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = {8'd0, b};
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next = len_full;
                    kept_len = len_full;
                    if (type_reg != 8'd0 && len_full > ctrl.cmd_limit)
                    begin
                        ev       = frp_pkg::EV_TOO_LARGE;
                        keep_hdr = 1'b1;
                        abort    = 1'b1;
                    end
                    else if (type_reg == 8'd0 &&
                             fill_sum > SUM_W'(PRINT_BUFFER_BYTES))
                    begin
                        ev       = frp_pkg::EV_FULL;
                        keep_hdr = 1'b1;
                        abort    = 1'b1;
                    end
                    else if (len_full == 16'd0)
                    begin
                        check_next = 3'd0;
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    data = b;
                    if (type_reg == 8'd0)
                    begin
                        ev        = frp_pkg::EV_PRINT;
                        addr      = 16'(fill_reg);
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    else
                    begin
                        ev   = frp_pkg::EV_CMD;
                        addr = pos_reg;
                    end
                    pos_next = pos_inc;
                    if (pos_inc == len_reg)
                    begin
                        check_next = 3'd0;
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    check_next = check_inc;
                    if (check_inc == frp_pkg::CHECK_BYTES)
                    begin
                        phase_next = PH_END;
                    end
                end
                PH_END:
                begin
                    keep_hdr = 1'b1;
                    if (b == frp_pkg::END_MARK)
                    begin
                        ev         = frp_pkg::EV_DONE;
                        phase_next = PH_WAIT;
                        type_next  = 8'd0;
                        index_next = 8'd0;
                        len_next   = 16'd0;
                        pos_next   = 16'd0;
                        check_next = 3'd0;
                    end
                    else
                    begin
                        ev    = frp_pkg::EV_NO_END;
                        abort = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase

            // Abort: roll back the print count, drop the frame, and restart
            // at once when the offending byte is itself a start byte.
            if (abort)
            begin
                fill_next  = rollback_fill;
                type_next  = 8'd0;
                index_next = 8'd0;
                len_next   = 16'd0;
                pos_next   = 16'd0;
                check_next = 3'd0;
                phase_next = PH_WAIT;
                if (b == frp_pkg::START_MARK)
                begin
                    start_fill_next = rollback_fill;
                    phase_next      = PH_TYPE;
                    resync          = 1'b1;
                end
            end
        end
    end

    // Assemble the result item.
    always_comb
    begin
        result.event_res   = ev;
        result.write_addr  = addr;
        result.write_data  = data;
        result.frame_type  = keep_hdr ? type_reg : type_next;
        result.frame_index = keep_hdr ? index_reg : index_next;
        result.frame_len   = keep_hdr ? kept_len : len_next;
        result.print_count = 17'(fill_next);
        result.resynced    = resync;
    end

    // Frame state advances once per parsed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT;
            type_reg       <= 8'd0;
            index_reg      <= 8'd0;
            len_reg        <= 16'd0;
            pos_reg        <= 16'd0;
            check_reg      <= 3'd0;
            fill_reg       <= '0;
            start_fill_reg <= '0;
        end
        else if (ctrl.step)
        begin
            phase_reg      <= phase_next;
            type_reg       <= type_next;
            index_reg      <= index_next;
            len_reg        <= len_next;
            pos_reg        <= pos_next;
            check_reg      <= check_next;
            fill_reg       <= fill_next;
            start_fill_reg <= start_fill_next;
        end
    end

endmodule

[src/frp_checker.sv]
module frp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input frp_pkg::frp_out_t out_data
);

    // A stalled result item holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    // Only defined event codes are reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.event_res <= frp_pkg::EV_NO_END)
        else $error("undefined event code");

    // A resync only ever comes with an abort.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.resynced |->
            (out_data.event_res == frp_pkg::EV_TOO_LARGE ||
             out_data.event_res == frp_pkg::EV_FULL ||
             out_data.event_res == frp_pkg::EV_NO_END))
        else $error("resync without an abort");

    // Write address and data are zero unless a payload byte is written.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_res != frp_pkg::EV_PRINT &&
            out_data.event_res != frp_pkg::EV_CMD |->
            out_data.write_addr == 16'd0 && out_data.write_data == 8'd0)
        else $error("write fields set without a payload write");

endmodule

bind framed_packet_receiver frp_checker u_frp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[sim/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_BYTES   = 65536;
    localparam int CYCLE_LIMIT = 1000000;

    // Parser phases of the frame predictor.
    typedef enum logic [7:0] {
        P_WAIT    = 8'b0000_0001,
        P_TYPE    = 8'b0000_0010,
        P_INDEX   = 8'b0000_0100,
        P_LEN_LO  = 8'b0000_1000,
        P_LEN_HI  = 8'b0001_0000,
        P_PAYLOAD = 8'b0010_0000,
        P_CHECK   = 8'b0100_0000,
        P_END     = 8'b1000_0000
    } parse_phase_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    frp_pkg::frp_in_t  in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    frp_pkg::frp_out_t out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [15:0]       cfg_data  = '0;

    // Items waiting to be sent and results waiting to be seen.
    frp_pkg::frp_in_t  rx_stream_q[$];
    frp_pkg::frp_out_t expected_events_q[$];
    frp_pkg::frp_out_t due_result;

    int send_idle_pct = 29;
    int recv_idle_pct = 65;
    int fail_count    = 0;
    int pushed_count  = 0;
    int cycle_count   = 0;

    // The stream generator left the parser resynchronized on a start byte.
    bit resync_armed = 1'b0;

    // Predictor copy of the parser state and of the limit register.
    parse_phase_t rx_phase   = P_WAIT;
    logic [7:0]   hdr_type   = '0;
    logic [7:0]   hdr_index  = '0;
    logic [15:0]  hdr_len    = '0;
    logic [15:0]  pay_pos    = '0;
    logic [2:0]   chk_pos    = '0;
    logic [16:0]  print_fill = '0;
    logic [16:0]  sof_fill   = '0;
    logic [15:0]  cmd_limit  = frp_pkg::CMD_LIMIT_RESET;

    framed_packet_receiver #(
        .PRINT_BUFFER_BYTES(BUF_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Forget the frame header and go back to hunting for a start byte.
    function automatic void clear_header();
        rx_phase  = P_WAIT;
        pay_pos   = '0;
        chk_pos   = '0;
        hdr_type  = '0;
        hdr_index = '0;
        hdr_len   = '0;
    endfunction

    function automatic void open_frame();
        clear_header();
        sof_fill = print_fill;
        rx_phase = P_TYPE;
    endfunction

    // Abort the frame; returns 1 when the aborting byte starts a new one.
    function automatic logic drop_frame(logic [7:0] b);
        if (hdr_type == 8'h00 && print_fill > sof_fill)
            print_fill = sof_fill;
        clear_header();
        if (b == frp_pkg::START_MARK)
        begin
            open_frame();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the parser by one item and return the result it must produce.
    function automatic frp_pkg::frp_out_t predict_frame_step(frp_pkg::frp_in_t item);
        frp_pkg::frp_out_t res;
        logic              hold_hdr;
        logic [7:0]        b;
        res             = '0;
        hold_hdr        = 1'b0;
        b               = item.rx_byte;
        res.frame_type  = hdr_type;
        res.frame_index = hdr_index;
        res.frame_len   = hdr_len;
        if (item.kind == frp_pkg::KIND_CLEAR)
            print_fill = '0;
        else
        begin
            case (rx_phase)
                P_WAIT:
                begin
                    if (b == frp_pkg::START_MARK)
                        open_frame();
                end
                P_TYPE:
                begin
                    hdr_type = b;
                    rx_phase = P_INDEX;
                end
                P_INDEX:
                begin
                    hdr_index = b;
                    rx_phase  = P_LEN_LO;
                end
                P_LEN_LO:
                begin
                    hdr_len  = {8'h00, b};
                    rx_phase = P_LEN_HI;
                end
                P_LEN_HI:
                begin
                    hdr_len[15:8] = b;
                    res.frame_len = hdr_len;
                    if (hdr_type != 8'h00 && hdr_len > cmd_limit)
                    begin
                        res.event_res = frp_pkg::EV_TOO_LARGE;
                        hold_hdr      = 1'b1;
                        res.resynced  = drop_frame(b);
                    end
                    else if (hdr_type == 8'h00 &&
                             32'(print_fill) + 32'(hdr_len) > BUF_BYTES)
                    begin
                        res.event_res = frp_pkg::EV_FULL;
                        hold_hdr      = 1'b1;
                        res.resynced  = drop_frame(b);
                    end
                    else
                        rx_phase = (hdr_len == 16'd0) ? P_CHECK : P_PAYLOAD;
                end
                P_PAYLOAD:
                begin
                    res.write_data = b;
                    if (hdr_type == 8'h00)
                    begin
                        res.event_res  = frp_pkg::EV_PRINT;
                        res.write_addr = print_fill[15:0];
                        print_fill     = print_fill + 17'd1;
                    end
                    else
                    begin
                        res.event_res  = frp_pkg::EV_CMD;
                        res.write_addr = pay_pos;
                    end
                    pay_pos = pay_pos + 16'd1;
                    if (pay_pos == hdr_len)
                    begin
                        chk_pos  = '0;
                        rx_phase = P_CHECK;
                    end
                end
                P_CHECK:
                begin
                    chk_pos = chk_pos + 3'd1;
                    if (chk_pos == frp_pkg::CHECK_BYTES)
                        rx_phase = P_END;
                end
                default:
                begin
                    hold_hdr = 1'b1;
                    if (b == frp_pkg::END_MARK)
                    begin
                        res.event_res = frp_pkg::EV_DONE;
                        clear_header();
                    end
                    else
                    begin
                        res.event_res = frp_pkg::EV_NO_END;
                        res.resynced  = drop_frame(b);
                    end
                end
            endcase
        end
        if (!hold_hdr)
        begin
            res.frame_type  = hdr_type;
            res.frame_index = hdr_index;
            res.frame_len   = hdr_len;
        end
        res.print_count = print_fill;
        return res;
    endfunction

    task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Sender: predict each accepted item, then offer the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_events_q.push_back(predict_frame_step(in_data));
            if (!in_valid || in_ready)
            begin
                if (rx_stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= rx_stream_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: compare each accepted result with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_events_q.size() == 0)
                begin
                    $error("result item arrived with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    due_result = expected_events_q.pop_front();
                    field_check("event_res", 32'(due_result.event_res),
                                32'(out_data.event_res));
                    field_check("write_addr", 32'(due_result.write_addr),
                                32'(out_data.write_addr));
                    field_check("write_data", 32'(due_result.write_data),
                                32'(out_data.write_data));
                    field_check("frame_type", 32'(due_result.frame_type),
                                32'(out_data.frame_type));
                    field_check("frame_index", 32'(due_result.frame_index),
                                32'(out_data.frame_index));
                    field_check("frame_len", 32'(due_result.frame_len),
                                32'(out_data.frame_len));
                    field_check("print_count", 32'(due_result.print_count),
                                32'(out_data.print_count));
                    field_check("resynced", 32'(due_result.resynced),
                                32'(out_data.resynced));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_item(logic kind, logic [7:0] value);
        frp_pkg::frp_in_t item;
        item.kind    = kind;
        item.rx_byte = value;
        rx_stream_q.push_back(item);
        pushed_count++;
    endtask

    task automatic push_byte(logic [7:0] value);
        push_item(frp_pkg::KIND_BYTE, value);
    endtask

    task automatic push_clear();
        push_item(frp_pkg::KIND_CLEAR, 8'($urandom_range(255)));
    endtask

    // Queue one frame. A frame that will be refused at its length is cut
    // there; a start byte in the aborting position leaves the parser in a
    // new frame, so the next frame is sent without its own start byte.
    task automatic send_frame(logic [7:0] ftype, logic [7:0] findex, logic [15:0] flen,
                              bit cut_at_header, logic [7:0] tail_byte, bit with_clear);
        int clear_at;
        if (resync_armed)
            resync_armed = 1'b0;
        else
            push_byte(frp_pkg::START_MARK);
        push_byte(ftype);
        push_byte(findex);
        push_byte(flen[7:0]);
        push_byte(flen[15:8]);
        if (cut_at_header)
        begin
            if (flen[15:8] == frp_pkg::START_MARK)
                resync_armed = 1'b1;
            return;
        end
        clear_at = (with_clear && flen != 16'd0) ? int'($urandom_range(int'(flen) - 1)) : -1;
        for (int i = 0; i < int'(flen); i++)
        begin
            if (i == clear_at)
                push_clear();
            push_byte(($urandom_range(7) == 0) ? frp_pkg::START_MARK
                                               : 8'($urandom_range(255)));
        end
        repeat (4)
            push_byte(8'($urandom_range(255)));
        push_byte(tail_byte);
        if (tail_byte == frp_pkg::START_MARK)
            resync_armed = 1'b1;
    endtask

    // Mostly the proper end byte, sometimes a start byte or some other byte.
    function automatic logic [7:0] pick_tail_byte();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 85)
            return frp_pkg::END_MARK;
        if (pick < 92)
            return frp_pkg::START_MARK;
        b = 8'($urandom_range(255));
        if (b == frp_pkg::START_MARK || b == frp_pkg::END_MARK)
            b = b ^ 8'h80;
        return b;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (rx_stream_q.size() != 0 || in_valid || expected_events_q.size() != 0);
    endtask

    task automatic write_limit(logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cmd_limit = value;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Random frames, with noise, clears and refused frames mixed in.
    task automatic random_traffic(int count);
        int          stop_at;
        int          next_pause;
        int          pick;
        logic [7:0]  ftype;
        logic [7:0]  noise;
        logic [15:0] flen;
        stop_at    = pushed_count + count;
        next_pause = pushed_count + int'($urandom_range(150, 60));
        while (pushed_count < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 6 && !resync_armed)
            begin
                noise = 8'($urandom_range(255));
                push_byte((noise == frp_pkg::START_MARK) ? ~noise : noise);
            end
            else if (pick < 12)
                push_clear();
            else if (pick < 20)
            begin
                // A short print frame guarantees the next huge one overflows.
                send_frame(8'h00, 8'($urandom_range(255)), 16'd2, 1'b0,
                           frp_pkg::END_MARK, 1'b0);
                send_frame(8'h00, 8'($urandom_range(255)), 16'hFFFF, 1'b1,
                           frp_pkg::END_MARK, 1'b0);
            end
            else
            begin
                ftype = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
                flen  = 16'($urandom_range(10));
                if (ftype != 8'h00 && cmd_limit != 16'hFFFF)
                begin
                    pick = $urandom_range(99);
                    if (pick < 15 && cmd_limit < 16'h0200)
                        flen = {frp_pkg::START_MARK, 8'($urandom_range(255))};
                    else if (pick < 30)
                        flen = cmd_limit + 16'd1;
                    else if (pick < 45 && cmd_limit <= 16'd64)
                        flen = cmd_limit;
                end
                send_frame(ftype, 8'($urandom_range(255)), flen,
                           ftype != 8'h00 && flen > cmd_limit, pick_tail_byte(),
                           $urandom_range(9) == 0);
            end
            // Now and then hold the sender until every result is back.
            if (pushed_count >= next_pause)
            begin
                wait_drained();
                next_pause = pushed_count + int'($urandom_range(150, 60));
            end
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset limit.
        push_byte(8'hFF);
        push_byte(8'h00);
        push_clear();
        send_frame(8'h00, 8'hFF, 16'd3, 1'b0, frp_pkg::END_MARK, 1'b0);
        send_frame(8'hFF, 8'h00, 16'd0, 1'b0, frp_pkg::END_MARK, 1'b0);
        send_frame(8'h01, 8'h80, frp_pkg::CMD_LIMIT_RESET + 16'd1, 1'b1,
                   frp_pkg::END_MARK, 1'b0);
        send_frame(8'h00, 8'h01, 16'd2, 1'b0, frp_pkg::END_MARK, 1'b0);
        send_frame(8'h00, 8'h02, 16'hFFFF, 1'b1, frp_pkg::END_MARK, 1'b0);
        send_frame(8'h00, 8'h03, 16'd2, 1'b0, frp_pkg::START_MARK, 1'b0);
        send_frame(8'h7F, 8'h04, 16'd1, 1'b0, 8'h7F, 1'b0);
        send_frame(8'h00, 8'h05, 16'd4, 1'b0, frp_pkg::END_MARK, 1'b1);
        wait_drained();

        // Smallest limit: every non-empty command frame is refused.
        write_limit(16'd0);
        random_traffic(330);
        wait_drained();

        // Largest limit, with the idle rates swapped.
        send_idle_pct = 65;
        recv_idle_pct = 29;
        write_limit(16'hFFFF);
        random_traffic(330);
        wait_drained();

        // Small random limit and no idling at all.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(16'($urandom_range(12, 1)));
        random_traffic(340);

        // With two bytes held, the largest print frame overflows by one byte.
        push_clear();
        send_frame(8'h00, 8'($urandom_range(255)), 16'd2, 1'b0, frp_pkg::END_MARK, 1'b0);
        send_frame(8'h00, 8'($urandom_range(255)), 16'hFFFF, 1'b1, frp_pkg::END_MARK, 1'b0);
        send_frame(8'h00, 8'($urandom_range(255)), 16'd0, 1'b0, frp_pkg::END_MARK, 1'b0);
        push_clear();
        wait_drained();

        // Let any stray result show up before the verdict.
        repeat (10)
            @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[framed_packet_receiver.f]
src/frp_pkg.sv
src/frp_parser.sv
src/framed_packet_receiver.sv
src/frp_checker.sv
sim/testbench.sv
